@@ sv/ots_pkg.sv @@
// Shared constants and control types for the odd-even transposition sorter.
package ots_pkg;

  localparam int MAX_VALUES = 16;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(MAX_VALUES);
  localparam int CNT_W      = $clog2(MAX_VALUES + 1);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SORT = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic             load;
    logic             sort;
    logic             shift;
    logic             odd;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] count;
  } ctl_t;

endpackage

@@ sv/ots_if.sv @@
// Valid/ready channel interfaces for the sorter input and output beats.
interface ots_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ots_pkg::DATA_W-1:0]   value;
  logic                                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ots_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ots_pkg::DATA_W-1:0]   sorted_value;
  logic                                final_res;

  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

@@ sv/ots_cell.sv @@
// One sorter cell: holds a value, loads, compare-exchanges with a neighbor, shifts.
module ots_cell (
  input  logic                              clk,
  input  ots_pkg::ctl_t                     ctl,
  input  logic [ots_pkg::IDX_W-1:0]         idx,
  input  logic signed [ots_pkg::DATA_W-1:0] din,
  input  logic signed [ots_pkg::DATA_W-1:0] left,
  input  logic signed [ots_pkg::DATA_W-1:0] right,
  output logic signed [ots_pkg::DATA_W-1:0] q
);

  logic [ots_pkg::CNT_W-1:0]         pos;
  logic                              lo;
  logic                              hi;
  logic signed [ots_pkg::DATA_W-1:0] q_next;

  assign pos = ots_pkg::CNT_W'(idx);
  // lower member of a pair takes the min, upper member the max
  assign lo = ctl.sort && (idx[0] == ctl.odd) && ((pos + 1'b1) < ctl.count);
  assign hi = ctl.sort && (idx[0] != ctl.odd) && (pos != '0) && (pos < ctl.count);

  always_comb begin
    q_next = q;
    if (ctl.load && (idx == ctl.wr_idx)) begin
      q_next = din;
    end else if (ctl.shift) begin
      q_next = right;
    end else if (lo) begin
      q_next = (q > right) ? right : q;
    end else if (hi) begin
      q_next = (left > q) ? left : q;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ sv/ots_ctrl.sv @@
// Sequencer: load count, phase counter and emit countdown for the cell row.
module ots_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          final_res,
  output ots_pkg::ctl_t ctl
);

  ots_pkg::state_t           state, state_next;
  logic [ots_pkg::CNT_W-1:0] count, count_next;
  logic [ots_pkg::CNT_W-1:0] phase, phase_next;
  logic                      in_fire;
  logic                      out_fire;
  logic [ots_pkg::CNT_W-1:0] count_inc;

  assign in_ready  = (state == ots_pkg::S_LOAD);
  assign out_valid = (state == ots_pkg::S_EMIT);
  assign final_res = (count == ots_pkg::CNT_W'(1));
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign count_inc = count + 1'b1;

  assign ctl.load   = in_fire;
  assign ctl.sort   = (state == ots_pkg::S_SORT);
  assign ctl.shift  = out_fire;
  assign ctl.odd    = phase[0];
  assign ctl.wr_idx = count[ots_pkg::IDX_W-1:0];
  assign ctl.count  = count;

  always_comb begin
    state_next = state;
    count_next = count;
    phase_next = phase;
    unique case (state)
      ots_pkg::S_LOAD: begin
        if (in_fire) begin
          count_next = count_inc;
          phase_next = '0;
          if (in_last || (count_inc == ots_pkg::CNT_W'(ots_pkg::MAX_VALUES))) begin
            state_next = ots_pkg::S_SORT;
          end
        end
      end
      ots_pkg::S_SORT: begin
        phase_next = phase + 1'b1;
        if (phase_next == count) begin
          state_next = ots_pkg::S_EMIT;
          phase_next = '0;
        end
      end
      ots_pkg::S_EMIT: begin
        if (out_fire) begin
          count_next = count - 1'b1;
          if (final_res) begin
            state_next = ots_pkg::S_LOAD;
          end
        end
      end
      default: begin
        state_next = ots_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ots_pkg::S_LOAD;
      count <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      phase <= phase_next;
    end
  end

endmodule

@@ sv/odd_even_transposition_sorter_unit.sv @@
// Top level of the odd-even transposition sorter: sequencer plus a row of cells.
//
// Input channel in_ch carries signed values; a beat with last set closes the
// batch, and so does the beat that fills all MAX_VALUES cells. Beats are
// written one per cycle into successive cells.
// After close, the row runs one compare-exchange phase per cycle, as many
// phases as the batch holds values (even phases pair cells 0-1, 2-3, ...;
// odd phases pair 1-2, 3-4, ...). Input ready is low from close until the
// last result beat has been taken.
// Output channel out_ch then gives the batch in ascending order from cell 0,
// the row shifting down by one on every accepted beat; final_res marks the
// last beat. A stall on out_ch simply holds the current beat.
// A batch passes through the load, sort and emit states in turn; the sort
// length is set by the phase counter.
// Reset (rst, synchronous) returns to loading with an empty batch; cell
// contents are not cleared since only written cells are ever read.
module odd_even_transposition_sorter_unit (
  input logic       clk,
  input logic       rst,
  ots_in_if.sink    in_ch,
  ots_out_if.source out_ch
);

  localparam int N = ots_pkg::MAX_VALUES;

  ots_pkg::ctl_t                     ctl;
  logic signed [ots_pkg::DATA_W-1:0] cell_q [N];

  ots_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .final_res (out_ch.final_res),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [ots_pkg::DATA_W-1:0] left_q;
    logic signed [ots_pkg::DATA_W-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    ots_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   ((ots_pkg::IDX_W)'(i)),
      .din   (in_ch.value),
      .left  (left_q),
      .right (right_q),
      .q     (cell_q[i])
    );
  end

  assign out_ch.sorted_value = cell_q[0];

endmodule

@@ verif/tb_odd_even_transposition_sorter_unit.sv @@
// Testbench for the odd-even transposition sorter: directed and random batches checked against a batch sort.
module tb_odd_even_transposition_sorter_unit;

  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT_BEAT = 40;
  localparam int SETTLE       = 3 * ots_pkg::MAX_VALUES + 16;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic signed [ots_pkg::DATA_W-1:0] sorted_value;
    logic                              final_res;
  } sorted_beat_t;

  class sort_scoreboard;
    logic signed [ots_pkg::DATA_W-1:0] open_batch[$];
    sorted_beat_t                      sorted_q[$];
    int                                errors = 0;

    // A beat with last, or the one that fills the store, closes the batch.
    function void note_input(logic signed [ots_pkg::DATA_W-1:0] value, logic last);
      logic signed [ots_pkg::DATA_W-1:0] tmp;
      sorted_beat_t                      beat;
      int                                n;
      open_batch.push_back(value);
      if (!last && open_batch.size() < ots_pkg::MAX_VALUES) return;
      n = open_batch.size();
      for (int phase = 0; phase < n; phase++) begin
        for (int i = (phase % 2) + 1; i < n; i += 2) begin
          if (open_batch[i-1] > open_batch[i]) begin
            tmp             = open_batch[i-1];
            open_batch[i-1] = open_batch[i];
            open_batch[i]   = tmp;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        beat.sorted_value = open_batch[k];
        beat.final_res    = (k == n - 1);
        sorted_q.push_back(beat);
      end
      open_batch.delete();
    endfunction

    function void check_result(logic signed [ots_pkg::DATA_W-1:0] value, logic final_res);
      sorted_beat_t want;
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got value %0d final_res %0b",
                 $time, value, final_res);
        errors++;
        return;
      end
      want = sorted_q.pop_front();
      if (value !== want.sorted_value) begin
        $display("%0t: sorted_value expected %0d, got %0d", $time, want.sorted_value, value);
        errors++;
      end
      if (final_res !== want.final_res) begin
        $display("%0t: final_res expected %0b, got %0b", $time, want.final_res, final_res);
        errors++;
      end
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;

  logic signed [ots_pkg::DATA_W-1:0] full_batch[ots_pkg::MAX_VALUES] = '{
    32'sh7fffffff, 9, 9, -3, 32'sh80000000, 0, -1, 1,
    100, -100, 9, 32'sh80000000, 32'sh7fffffff, 7, 6, 5
  };
  logic signed [ots_pkg::DATA_W-1:0] edge_batch[5] = '{
    32'sh7fffffff, 1, 0, -1, 32'sh80000000
  };

  ots_in_if  in_ch();
  ots_out_if out_ch();

  sort_scoreboard scoreboard = new();

  odd_even_transposition_sorter_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [ots_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic signed [ots_pkg::DATA_W-1:0] value, input logic last,
                           input bit fast);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.last  <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    scoreboard.note_input(value, last);
  endtask

  // Receiver; holds off once for a long stretch so the block backs up.
  task automatic take_results();
    int stall;
    int taken;
    bit fast;
    taken = 0;
    fast  = 1'b0;
    forever begin
      if (taken % 16 == 0) fast = ($urandom_range(0, 3) == 0);
      stall = fast ? 0 : $urandom_range(0, 15);
      if (taken == HOLD_AT_BEAT) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      scoreboard.check_result(out_ch.sorted_value, out_ch.final_res);
      taken++;
    end
  endtask

  initial begin
    int  items_sent;
    int  n;
    bit  fill_close;
    bit  fast;

    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    out_ch.ready <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none

    // single value, full store closing without last, extremes, equal pair
    send_beat(32'sh80000000, 1'b1, 1'b0);
    foreach (full_batch[i]) send_beat(full_batch[i], 1'b0, 1'b1);
    foreach (edge_batch[i]) send_beat(edge_batch[i], i == 4, 1'b0);
    send_beat(5, 1'b0, 1'b1);
    send_beat(5, 1'b1, 1'b1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      n          = $urandom_range(1, ots_pkg::MAX_VALUES);
      fill_close = ($urandom_range(0, 4) == 0);
      fast       = ($urandom_range(0, 3) == 0);
      if (fill_close) n = ots_pkg::MAX_VALUES;
      for (int k = 0; k < n; k++) send_beat(pick_value(), !fill_close && k == n - 1, fast);
      items_sent += n;
    end
    in_ch.valid <= 1'b0;

    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (scoreboard.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ odd_even_transposition_sorter_unit.f @@
sv/ots_pkg.sv
sv/ots_if.sv
sv/ots_cell.sv
sv/ots_ctrl.sv
sv/odd_even_transposition_sorter_unit.sv
verif/tb_odd_even_transposition_sorter_unit.sv
